FILE: src/hes_pkg.sv
`timescale 1ns / 1ps
package hes_pkg;

  // Field widths
  localparam int WORD_W = 31;
  localparam int DATA_W = 26;
  localparam int LEN_W  = 5;
  localparam int PC_W   = 3;
  localparam int MAX_PC = 5;

  // Length limits and register reset value
  localparam int          CODE_BITS_DEF = 32;
  localparam int          LEN_MIN       = 1;
  localparam int          LEN_MAX       = 26;
  localparam logic [4:0]  LEN_RESET     = 5'd4;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Input request
  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] word;
  } hes_req_t;

  // Result
  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [PC_W-1:0]   parity_count;
    logic [LEN_W-1:0]  error_position;
  } hes_res_t;

  // Code geometry derived from the length register
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] clen;
    logic [PC_W-1:0]  pc;
  } hes_geom_t;

  // Pipeline stage contents
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [WORD_W-1:0] word;
  } hes_stage_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [WORD_W-1:0] word;
    logic [MAX_PC-1:0] par;
  } hes_par_t;

  // Parity bits needed for n data bits
  function automatic logic [PC_W-1:0] parity_for(logic [LEN_W-1:0] n);
    logic [PC_W-1:0] p;
    if (n <= 5'd1) p = 3'd2;
    else if (n <= 5'd4) p = 3'd3;
    else if (n <= 5'd11) p = 3'd4;
    else p = 3'd5;
    return p;
  endfunction

  // Largest data length whose code fits in min(code_bits - 1, 31) positions
  function automatic int max_len(int code_bits);
    int lim;
    int res;
    lim = code_bits - 1;
    if (lim > WORD_W) lim = WORD_W;
    res = LEN_MIN;
    for (int n = LEN_MIN; n <= LEN_MAX; n++) begin
      if (n + int'(parity_for(LEN_W'(n))) <= lim) res = n;
    end
    return res;
  endfunction

  // Scatter data bits onto the positions that are not powers of two
  function automatic logic [WORD_W-1:0] place_data(logic [DATA_W-1:0] data,
                                                   logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] cw;
    int j;
    cw = '0;
    j  = 0;
    for (int pos = 1; pos <= WORD_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = data[j] & (LEN_W'(j) < len);
        j++;
      end
    end
    return cw;
  endfunction

  // Positions checked by parity bit k
  function automatic logic [WORD_W-1:0] cover_mask(int k);
    logic [WORD_W-1:0] m;
    for (int pos = 1; pos <= WORD_W; pos++) begin
      m[pos-1] = ((pos >> k) & 1) != 0;
    end
    return m;
  endfunction

endpackage

FILE: src/hamming_encode_and_syndrome.sv
`timescale 1ns / 1ps
// Channel   | Signals                          | Direction | Handshake
// ----------+----------------------------------+-----------+---------------------
// request   | start, busy, req_i               | in        | start & !busy
// result    | done_o, res_o                    | out       | one-cycle strobe
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i | in    | valid & ready
//
// One request per cycle; each result passes through the four register stages after its request
// is taken: input, bit placement, parity trees, output merge.
// busy is held low and cfg_ready_o high: the pipeline has no stall path.
// Reset clears the stage valid bits and loads a data length of 4.
// done_o is high for exactly one cycle per result; the receiver cannot hold it off.
module hamming_encode_and_syndrome import hes_pkg::*; #(
  parameter int CodeBits = CODE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  hes_req_t         req_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i,
  output logic             done_o,
  output hes_res_t         res_o
);

  hes_geom_t         geom;
  hes_stage_t        in_q;
  hes_stage_t        place_st;
  hes_par_t          par_st;
  hes_res_t          res_d, res_q;
  logic              done_q;
  logic [WORD_W-1:0] par_bits;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  hes_cfg #(
    .CodeBits(CodeBits)
  ) u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (cfg_valid_i & cfg_ready_o),
    .data_i(cfg_data_i),
    .geom_o(geom)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else begin
      in_q.valid <= start & ~busy;
      in_q.op    <= req_i.operation;
      in_q.word  <= req_i.word;
    end
  end

  hes_place u_place (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_q),
    .geom_i(geom),
    .out_o (place_st)
  );

  hes_parity u_parity (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (place_st),
    .geom_i(geom),
    .out_o (par_st)
  );

  // Parity bit k lands at position 2^k
  always_comb begin
    par_bits = '0;
    for (int k = 0; k < MAX_PC; k++) begin
      par_bits[(1 << k) - 1] = par_st.par[k];
    end
  end

  // Output merge
  always_comb begin
    res_d.code_length  = geom.clen;
    res_d.parity_count = geom.pc;
    if (par_st.op == OP_CHECK) begin
      res_d.code_word      = '0;
      res_d.error_position = par_st.par;
    end else begin
      res_d.code_word      = par_st.word | par_bits;
      res_d.error_position = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= par_st.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: src/hes_cfg.sv
`timescale 1ns / 1ps
module hes_cfg import hes_pkg::*; #(
  parameter int CodeBits = CODE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [LEN_W-1:0] data_i,
  output hes_geom_t        geom_o
);

  localparam logic [LEN_W-1:0] LenLimit = LEN_W'(max_len(CodeBits));

  logic [LEN_W-1:0] data_length_q;
  logic [LEN_W-1:0] len;

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q <= LEN_RESET;
    end else if (wr_i) begin
      data_length_q <= data_i;
    end
  end

  // Clamp to the legal range, then to what fits in the code word
  always_comb begin
    if (data_length_q < LEN_W'(LEN_MIN)) len = LEN_W'(LEN_MIN);
    else if (data_length_q > LEN_W'(LEN_MAX)) len = LEN_W'(LEN_MAX);
    else len = data_length_q;
    if (len > LenLimit) len = LenLimit;
  end

  assign geom_o.len  = len;
  assign geom_o.pc   = parity_for(len);
  assign geom_o.clen = len + LEN_W'(geom_o.pc);

endmodule

FILE: src/hes_place.sv
`timescale 1ns / 1ps
module hes_place import hes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hes_stage_t in_i,
  input  hes_geom_t  geom_i,
  output hes_stage_t out_o
);

  logic [WORD_W-1:0] clen_mask;
  hes_stage_t        st_d, st_q;

  // Keep only positions inside the code
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      clen_mask[i] = LEN_W'(i) < geom_i.clen;
    end
  end

  // Encode: data onto code positions, parity slots left zero; check: mask
  always_comb begin
    st_d.valid = in_i.valid;
    st_d.op    = in_i.op;
    if (in_i.op == OP_CHECK) st_d.word = in_i.word & clen_mask;
    else st_d.word = place_data(in_i.word[DATA_W-1:0], geom_i.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule

FILE: src/hes_parity.sv
`timescale 1ns / 1ps
module hes_parity import hes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hes_stage_t in_i,
  input  hes_geom_t  geom_i,
  output hes_par_t   out_o
);

  hes_par_t st_d, st_q;

  // One XOR tree per parity bit; bits beyond the parity count stay zero
  always_comb begin
    st_d.valid = in_i.valid;
    st_d.op    = in_i.op;
    st_d.word  = in_i.word;
    for (int k = 0; k < MAX_PC; k++) begin
      st_d.par[k] = (^(in_i.word & cover_mask(k))) & (PC_W'(k) < geom_i.pc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule

FILE: src/hes_checker.sv
`timescale 1ns / 1ps
module hes_checker import hes_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input hes_req_t         req_i,
  input logic             done_o,
  input hes_res_t         res_o
);

  // Every taken request yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result missing four cycles after request");

  // No result without an earlier taken request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, 4))
    else $error("result without matching request");

  // Check results carry no code word, encode results no error position
  a_op_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4
      ((!$past(req_i.operation, 4) && res_o.error_position == 5'd0) ||
       ($past(req_i.operation, 4) && res_o.code_word == '0)))
    else $error("result fields do not match operation");

  // Code length agrees with parity count
  a_geometry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      ((res_o.parity_count == 3'd2 && res_o.code_length == 5'd3) ||
       (res_o.parity_count == 3'd3 && res_o.code_length >= 5'd5 &&
        res_o.code_length <= 5'd7) ||
       (res_o.parity_count == 3'd4 && res_o.code_length >= 5'd9 &&
        res_o.code_length <= 5'd15) ||
       (res_o.parity_count == 3'd5 && res_o.code_length >= 5'd17)))
    else $error("code length inconsistent with parity count");

endmodule

bind hamming_encode_and_syndrome hes_checker u_hes_checker (.*);

FILE: bench/hamming_encode_and_syndrome_test.sv
`timescale 1ns / 1ps
module hamming_encode_and_syndrome_test;
  import hes_pkg::*;

  // Predicts code words and syndromes, and holds the results still due
  class hamming_predictor;
    logic [LEN_W-1:0] length_reg;
    hes_res_t         expected_q[$];
    int unsigned      fail_count;

    function new();
      length_reg = LEN_RESET;
      fail_count = 0;
    endfunction

    // least p with 2^p - p - 1 >= n
    function int parity_bits(int n);
      int p;
      p = 0;
      while (((1 << p) - p - 1) < n) p++;
      return p;
    endfunction

    // clamp the register, then shrink until the code fits in 31 positions
    function void geometry(output int n, output int pc);
      n = length_reg;
      if (n < LEN_MIN) n = LEN_MIN;
      if (n > LEN_MAX) n = LEN_MAX;
      while (n > 1 && n + parity_bits(n) > WORD_W) n--;
      pc = parity_bits(n);
    endfunction

    function int code_len();
      int n, pc;
      geometry(n, pc);
      return n + pc;
    endfunction

    // even parity over positions 1..clen whose index has bit k set
    function bit group_parity(logic [WORD_W-1:0] cw, int clen, int k);
      bit acc;
      acc = 1'b0;
      for (int pos = 1; pos <= clen; pos++)
        if ((pos >> k) & 1) acc ^= cw[pos-1];
      return acc;
    endfunction

    function logic [WORD_W-1:0] encode(logic [WORD_W-1:0] data);
      int n, pc, clen, j;
      logic [WORD_W-1:0] cw;
      geometry(n, pc);
      clen = n + pc;
      cw = '0;
      j = 0;
      for (int pos = 1; pos <= clen; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          cw[pos-1] = data[j];
          j++;
        end
      end
      for (int k = 0; k < pc; k++)
        if (group_parity(cw, clen, k)) cw[(1 << k) - 1] = 1'b1;
      return cw;
    endfunction

    // raw syndrome; bits past the code length are dropped first
    function logic [LEN_W-1:0] syndrome(logic [WORD_W-1:0] rx);
      int n, pc, clen, sum;
      geometry(n, pc);
      clen = n + pc;
      sum = 0;
      for (int pos = clen + 1; pos <= WORD_W; pos++) rx[pos-1] = 1'b0;
      for (int k = 0; k < pc; k++)
        if (group_parity(rx, clen, k)) sum += 1 << k;
      return LEN_W'(sum);
    endfunction

    function void note_request(hes_req_t req);
      int n, pc;
      hes_res_t res;
      geometry(n, pc);
      res.code_length  = LEN_W'(n + pc);
      res.parity_count = PC_W'(pc);
      if (req.operation == OP_ENCODE) begin
        res.code_word      = encode(req.word);
        res.error_position = '0;
      end else begin
        res.code_word      = '0;
        res.error_position = syndrome(req.word);
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(hes_res_t res);
      hes_res_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res);
        fail_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (res.code_word !== exp_res.code_word) begin
        $display("%0t: code_word expected %h actual %h", $time,
                 exp_res.code_word, res.code_word);
        fail_count++;
      end
      if (res.code_length !== exp_res.code_length) begin
        $display("%0t: code_length expected %0d actual %0d", $time,
                 exp_res.code_length, res.code_length);
        fail_count++;
      end
      if (res.parity_count !== exp_res.parity_count) begin
        $display("%0t: parity_count expected %0d actual %0d", $time,
                 exp_res.parity_count, res.parity_count);
        fail_count++;
      end
      if (res.error_position !== exp_res.error_position) begin
        $display("%0t: error_position expected %0d actual %0d", $time,
                 exp_res.error_position, res.error_position);
        fail_count++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  hes_req_t         req_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i;
  logic             done_o;
  hes_res_t         res_o;

  hamming_predictor pred;

  hamming_encode_and_syndrome u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Monitor: results first, then the request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) pred.check_result(res_o);
      if (start && !busy) pred.note_request(req_i);
    end
  end

  // Present one request, with random idle cycles ahead of it
  task automatic send_request(input hes_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Hold off until every result is in, plus the pipeline depth
  task automatic drain_results();
    start <= 1'b0;
    while (pred.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pred.length_reg = value;
  endtask

  // Timeout guard
  initial begin
    #2_000_000;
    $display("** hamming_encode_and_syndrome: FAILED **");
    $finish;
  end

  initial begin
    hes_req_t          r;
    logic [WORD_W-1:0] cw;
    logic [LEN_W-1:0]  lengths[$];
    int                clen;
    int                sel;
    int                idle_pct;

    pred        = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset length, extremes and every single-bit error
    r.operation = OP_ENCODE;
    r.word = '0;
    send_request(r, 0);
    r.word = '1;
    send_request(r, 0);
    r.word = WORD_W'(5);
    send_request(r, 0);
    r.operation = OP_CHECK;
    r.word = '0;
    send_request(r, 0);
    r.word = '1;
    send_request(r, 0);
    for (int i = 0; i < 7; i++) begin
      r.word = pred.encode(WORD_W'(5)) ^ (WORD_W'(1) << i);
      send_request(r, 0);
    end
    drain_results();

    // Longest code
    write_length(5'd26);
    r.operation = OP_ENCODE;
    r.word = '1;
    send_request(r, 0);
    r.word = WORD_W'(26'h2AAAAAA);
    send_request(r, 0);
    r.operation = OP_CHECK;
    r.word = '1;
    send_request(r, 0);
    r.word = pred.encode('1) ^ (WORD_W'(1) << 30);
    send_request(r, 0);
    r.word = pred.encode('1) ^ WORD_W'(1);
    send_request(r, 0);
    drain_results();

    // Syndrome past the code end: length 2 gives a 5-bit code, 3 checks
    write_length(5'd2);
    r.word = WORD_W'(12);
    send_request(r, 0);
    r.word = '1;
    send_request(r, 0);
    drain_results();

    // Random phases over many lengths, including out-of-range values
    lengths = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd11, 5'd12, 5'd25,
                5'd26, 5'd27, 5'd31};
    lengths.push_back(LEN_W'($urandom_range(1, 26)));
    lengths.push_back(LEN_W'($urandom));
    foreach (lengths[ph]) begin
      write_length(lengths[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 47;
        default: idle_pct = 17;
      endcase
      clen = pred.code_len();
      for (int i = 0; i < 104; i++) begin
        if (i == 52) drain_results();
        r.operation = $urandom_range(1) ? OP_CHECK : OP_ENCODE;
        cw = WORD_W'($urandom);
        sel = $urandom_range(99);
        if (r.operation == OP_ENCODE) begin
          if (sel < 5) cw = '0;
          else if (sel < 10) cw = '1;
          r.word = cw;
        end else begin
          // mostly real code words with zero, one or two flips
          r.word = pred.encode(cw);
          if (sel < 35) begin
            r.word[$urandom_range(clen - 1)] ^= 1'b1;
          end else if (sel < 50) begin
            r.word[$urandom_range(clen - 1)] ^= 1'b1;
            r.word[$urandom_range(clen - 1)] ^= 1'b1;
          end else if (sel < 60) begin
            // noise above the code only
            for (int b = clen; b < WORD_W; b++) r.word[b] = cw[b];
          end else if (sel >= 80) begin
            r.word = WORD_W'($urandom);
          end
        end
        send_request(r, idle_pct);
      end
      drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (pred.fail_count == 0 && pred.expected_q.size() == 0) begin
      $display("** hamming_encode_and_syndrome: PASSED **");
    end else begin
      $display("** hamming_encode_and_syndrome: FAILED **");
    end
    $finish;
  end

endmodule
